[rtl/mfps_pkg.sv]
// ----------------------------------------------------------------------------
// mfps_pkg: shared types and helpers for the max falling path sum core
// Widths, row ring control structs, saturating add and output clamp.
// ----------------------------------------------------------------------------
package mfps_pkg;

    // Sizing
    localparam int MAX_COLUMNS = 256;
    localparam int SUM_WIDTH   = 32;
    localparam int CELL_W      = 16;
    localparam int OUT_W       = 32;
    localparam int CFG_W       = 9;
    localparam int COL_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int LEN_W       = $clog2(MAX_COLUMNS + 1);
    localparam int CMP_W       = (LEN_W > CFG_W) ? LEN_W : CFG_W;
    localparam int EXT_W       = (SUM_WIDTH > OUT_W) ? SUM_WIDTH : OUT_W;

    typedef logic signed [SUM_WIDTH-1:0] t_sum;
    typedef logic signed [CELL_W-1:0]    t_cell;
    typedef logic signed [OUT_W-1:0]     t_out;
    typedef logic [LEN_W-1:0]            t_len;
    typedef logic [COL_W-1:0]            t_col;
    typedef logic [CFG_W-1:0]            t_cfg;

    localparam t_sum SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam t_sum SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
    localparam t_out OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam t_out OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
    localparam t_cfg CFG_RESET = CFG_W'(256);

    // Per-cell control of the row ring
    typedef struct packed {
        logic shift;   // ring moves this cycle
        logic active;  // cell lies inside the current ring length
        logic tail;    // cell closes the ring and takes the wrap value
    } t_cell_ctl;

    // Neighbor selection for the cell update
    typedef struct packed {
        logic first_row;
        logic has_left;
        logic has_right;
    } t_head_ctl;

    // Request handed from the cell update to the result stage
    typedef struct packed {
        t_sum sum;
        logic col0;
        logic last;
    } t_stage;

    // Map the register value onto the usable width range
    function automatic t_len clamp_width(input t_cfg v);
        t_len w;
        if (v == '0) begin
            w = LEN_W'(1);
        end else if (CMP_W'(v) > CMP_W'(MAX_COLUMNS)) begin
            w = LEN_W'(MAX_COLUMNS);
        end else begin
            w = LEN_W'(v);
        end
        return w;
    endfunction

    // Add a cell to a sum, saturate to the sum range
    function automatic t_sum sat_add(input t_sum a, input t_cell b);
        logic [SUM_WIDTH:0] wide;
        t_sum               r;
        wide = {a[SUM_WIDTH-1], a} + (SUM_WIDTH+1)'(b);
        if (wide[SUM_WIDTH] != wide[SUM_WIDTH-1]) begin
            r = wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        end else begin
            r = t_sum'(wide[SUM_WIDTH-1:0]);
        end
        return r;
    endfunction

    // Clamp a sum to the output range
    function automatic t_out sat_out(input t_sum v);
        logic signed [EXT_W-1:0] e;
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] lo;
        t_out                    r;
        e  = EXT_W'(v);
        hi = EXT_W'(OUT_MAX);
        lo = EXT_W'(OUT_MIN);
        if (e > hi) begin
            r = OUT_MAX;
        end else if (e < lo) begin
            r = OUT_MIN;
        end else begin
            r = t_out'(e[OUT_W-1:0]);
        end
        return r;
    endfunction

endpackage

[rtl/max_falling_path_sum_core.sv]
// A final cell's result passes the stage register, then the output register.
// Throughput: one cell per cycle while the row width holds steady and the
// result output is not stalled. After an early final cell or a width change
// the row ring rotates back into line first, one entry per cycle.
// Reset: synchronous, active low; clears control, leaves the row ring as is.
// ----------------------------------------------------------------------------
// max_falling_path_sum_core: streaming maximum falling path sum
// Keeps the previous row of best sums in a ring of cells that rotates one
// entry per cell, so the head always shows the up and up-right neighbors.
// ----------------------------------------------------------------------------
module max_falling_path_sum_core
    import mfps_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    // configuration: row width
    input  logic  i_cfg_we,
    input  t_cfg  i_cfg_wdata,
    // cell requests
    input  logic  i_s_axis_tvalid,
    output logic  o_s_axis_tready,
    input  t_cell i_s_axis_tdata,   // [15:0] cell_value
    input  logic  i_s_axis_tlast,   // last_cell
    // results
    output logic  o_m_axis_tvalid,
    input  logic  i_m_axis_tready,
    output t_out  o_m_axis_tdata    // [31:0] best_path_sum
);

    t_cfg r_row_width;
    t_len r_len;
    t_col r_off;
    t_col r_col;
    logic r_first;
    t_sum r_left;

    t_len n_len;
    t_col n_off;
    t_col n_col;
    logic n_first;
    t_sum n_left;

    t_len      w_width;
    t_len      w_len_m1;
    t_col      w_eff_col;
    logic      w_row_end;
    logic      w_aligned;
    logic      w_len_switch;
    logic      w_rotate;
    logic      w_accept;
    logic      w_shift;
    logic      w_res_ready;
    t_sum      w_new_sum;
    t_sum      w_wrap_sum;
    t_head_ctl w_head_ctl;
    t_stage    w_stage;
    t_sum      w_sum [0:MAX_COLUMNS];

    // Hold the width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_row_width <= i_cfg_wdata;
        end
    end

    // Effective column and row end
    assign w_width  = clamp_width(r_row_width);
    assign w_len_m1 = r_len - LEN_W'(1);

    always_comb begin
        if (LEN_W'(r_col) >= w_width) begin
            w_eff_col = COL_W'(w_width - LEN_W'(1));
        end else begin
            w_eff_col = r_col;
        end
    end

    assign w_row_end = (LEN_W'(w_eff_col) + LEN_W'(1)) == w_width;

    // Ring alignment: head entry must be the current column
    assign w_aligned    = (r_len == w_width) && (r_off == w_eff_col);
    assign w_len_switch = (r_len != w_width) && (r_off == '0);
    assign w_rotate     = !w_aligned && !w_len_switch;

    assign o_s_axis_tready = w_aligned && w_res_ready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_shift         = w_accept || w_rotate;
    assign w_wrap_sum      = w_rotate ? w_sum[0] : w_new_sum;

    // Cell update
    assign w_head_ctl.first_row = r_first;
    assign w_head_ctl.has_left  = (w_eff_col != '0);
    assign w_head_ctl.has_right = !w_row_end;

    mfps_head u_head (
        .i_cell_value (i_s_axis_tdata),
        .i_up_sum     (w_sum[0]),
        .i_right_sum  (w_sum[1]),
        .i_left_sum   (r_left),
        .i_ctl        (w_head_ctl),
        .o_sum        (w_new_sum)
    );

    // Row ring
    assign w_sum[MAX_COLUMNS] = '0;

    for (genvar k = 0; k < MAX_COLUMNS; k++) begin : g_cell
        t_cell_ctl w_ctl;

        assign w_ctl.shift  = w_shift;
        assign w_ctl.active = LEN_W'(k) < r_len;
        assign w_ctl.tail   = LEN_W'(k) == w_len_m1;

        mfps_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_next_sum (w_sum[k+1]),
            .i_wrap_sum (w_wrap_sum),
            .o_sum      (w_sum[k])
        );
    end

    // Next control state
    always_comb begin
        n_len   = r_len;
        n_off   = r_off;
        n_col   = r_col;
        n_first = r_first;
        n_left  = r_left;
        if (w_len_switch) begin
            n_len = w_width;
        end
        if (w_shift) begin
            if ((LEN_W'(r_off) + LEN_W'(1)) == r_len) begin
                n_off = '0;
            end else begin
                n_off = r_off + COL_W'(1);
            end
        end
        if (w_accept) begin
            if (i_s_axis_tlast) begin
                n_col   = '0;
                n_first = 1'b1;
                n_left  = '0;
            end else begin
                if (!r_first) begin
                    n_left = w_sum[0];
                end
                if (w_row_end) begin
                    n_col   = '0;
                    n_first = 1'b0;
                end else begin
                    n_col = w_eff_col + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= LEN_W'(MAX_COLUMNS);
            r_off   <= '0;
            r_col   <= '0;
            r_first <= 1'b1;
            r_left  <= '0;
        end else begin
            r_len   <= n_len;
            r_off   <= n_off;
            r_col   <= n_col;
            r_first <= n_first;
            r_left  <= n_left;
        end
    end

    // Row maximum and result
    assign w_stage.sum  = w_new_sum;
    assign w_stage.col0 = (w_eff_col == '0);
    assign w_stage.last = i_s_axis_tlast;

    mfps_result u_result (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_accept),
        .i_stage  (w_stage),
        .o_ready  (w_res_ready),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata)
    );

endmodule

[rtl/mfps_cell.sv]
// ----------------------------------------------------------------------------
// mfps_cell: one entry of the row ring
// Holds one best path sum; on a shift takes its right neighbor's sum, or the
// wrap value when it is the ring's tail.
// ----------------------------------------------------------------------------
module mfps_cell
    import mfps_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_sum      i_next_sum,
    input  t_sum      i_wrap_sum,
    output t_sum      o_sum
);

    t_sum r_sum;
    t_sum n_sum;

    // Pick the incoming sum
    always_comb begin
        n_sum = i_ctl.tail ? i_wrap_sum : i_next_sum;
    end

    // Advance only inside the ring
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift && i_ctl.active) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

[rtl/mfps_head.sv]
// ----------------------------------------------------------------------------
// mfps_head: cell update at the head of the row ring
// Past the first row, takes the best of up to three sums above plus the cell.
// ----------------------------------------------------------------------------
module mfps_head
    import mfps_pkg::*;
(
    input  t_cell     i_cell_value,
    input  t_sum      i_up_sum,
    input  t_sum      i_right_sum,
    input  t_sum      i_left_sum,
    input  t_head_ctl i_ctl,
    output t_sum      o_sum
);

    t_sum w_best_ul;
    t_sum w_best;

    // Best of left and up, then right
    always_comb begin
        if (i_ctl.has_left && ($signed(i_left_sum) > $signed(i_up_sum))) begin
            w_best_ul = i_left_sum;
        end else begin
            w_best_ul = i_up_sum;
        end
        if (i_ctl.has_right && ($signed(i_right_sum) > $signed(w_best_ul))) begin
            w_best = i_right_sum;
        end else begin
            w_best = w_best_ul;
        end
    end

    // First row starts the path; later rows extend it
    always_comb begin
        if (i_ctl.first_row) begin
            o_sum = SUM_WIDTH'(i_cell_value);
        end else begin
            o_sum = sat_add(w_best, i_cell_value);
        end
    end

endmodule

[rtl/mfps_result.sv]
// ----------------------------------------------------------------------------
// mfps_result: row maximum and result register
// Tracks the largest sum of the current row and hands it out on a final cell.
// ----------------------------------------------------------------------------
module mfps_result
    import mfps_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_stage i_stage,
    output logic   o_ready,
    output logic   o_tvalid,
    input  logic   i_tready,
    output t_out   o_tdata
);

    logic   r_stage_valid;
    t_stage r_stage;
    t_sum   r_run_max;
    logic   r_out_valid;
    t_out   r_out_data;

    logic   w_advance;
    t_sum   n_run_max;

    // Stage moves on unless a final request meets a full, stalled output
    assign w_advance = r_stage_valid &&
                       (!r_stage.last || !r_out_valid || i_tready);
    assign o_ready   = !r_stage_valid || w_advance;

    // Running maximum; column zero restarts it
    always_comb begin
        if (r_stage.col0 || ($signed(r_stage.sum) > $signed(r_run_max))) begin
            n_run_max = r_stage.sum;
        end else begin
            n_run_max = r_run_max;
        end
    end

    // Stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_valid <= 1'b0;
        end else if (o_ready) begin
            r_stage_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_stage <= i_stage;
        end
    end

    // Row maximum, re-armed after a final cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_max <= SUM_MIN;
        end else if (w_advance) begin
            r_run_max <= r_stage.last ? SUM_MIN : n_run_max;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_stage.last) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_stage.last) begin
            r_out_data <= sat_out(n_run_max);
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;

endmodule

[rtl/mfps_checker.sv]
// ----------------------------------------------------------------------------
// mfps_checker: port-level checks for the max falling path sum core
// Watches the request and result channels over time.
// ----------------------------------------------------------------------------
module mfps_checker
    import mfps_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_s_axis_tvalid,
    input logic  o_s_axis_tready,
    input logic  i_s_axis_tlast,
    input logic  o_m_axis_tvalid,
    input logic  i_m_axis_tready,
    input t_out  o_m_axis_tdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // Drop any result on reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // A fresh result follows an accepted final cell
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |->
            $past(i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast, 2))
        else $error("result without a final cell");

    // A non-final cell never raises a result on its own
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid &&
            !$past(i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast)
            |=> !o_m_axis_tvalid)
        else $error("result raised by a non-final cell");

endmodule

bind max_falling_path_sum_core mfps_checker u_mfps_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
